[rtl/core/ftrb_pkg.sv]
// ----------------------------------------------------------------------------
// ftrb_pkg
// Shared types, constants and the record header encoder for the framed
// trace ring buffer.
// ----------------------------------------------------------------------------
package ftrb_pkg;

  localparam int unsigned RING_DEPTH_DEF = 1024;

  localparam int unsigned HDR_MAX_BYTES = 5;
  localparam int unsigned HDR_CNT_W     = 3;
  localparam int unsigned CFG_DATA_W    = 17;
  localparam int unsigned S_TDATA_W     = 64;
  localparam int unsigned M_TDATA_W     = 24;
  localparam int unsigned FILL_OUT_W    = 10;

  localparam logic CFG_CAPTURE_ENABLE = 1'b0;
  localparam logic CFG_WATCHED_INDEX  = 1'b1;

  localparam logic [31:0] LEN_LIMIT_1B = 32'd64;
  localparam logic [31:0] LEN_LIMIT_2B = 32'd8192;
  localparam logic [31:0] LEN_LIMIT_3B = 32'd1048576;
  localparam logic [31:0] LEN_LIMIT_4B = 32'd134217728;

  localparam logic [7:0] HDR_TAG_2B = 8'h40;
  localparam logic [7:0] HDR_TAG_3B = 8'h60;
  localparam logic [7:0] HDR_TAG_4B = 8'h70;
  localparam logic [7:0] HDR_TAG_5B = 8'h78;

  typedef enum logic [1:0] {
    ACT_HEADER  = 2'd0,
    ACT_PAYLOAD = 2'd1,
    ACT_READ    = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH,
    ST_RDATA,
    ST_DONE
  } state_t;

  typedef logic [HDR_MAX_BYTES-1:0][7:0] hdr_bytes_t;

  typedef struct packed {
    hdr_bytes_t           bytes;
    logic [HDR_CNT_W-1:0] count;
  } hdr_t;

  function automatic hdr_t encode_header(input logic dir, input logic [31:0] len);
    hdr_t       h;
    logic [7:0] d;
    d       = {dir, 7'd0};
    h.bytes = '0;
    if (len < LEN_LIMIT_1B) begin
      h.bytes[0] = d | 8'(len);
      h.count    = HDR_CNT_W'(1);
    end else if (len < LEN_LIMIT_2B) begin
      h.bytes[0] = d | HDR_TAG_2B | 8'(len >> 8);
      h.bytes[1] = len[7:0];
      h.count    = HDR_CNT_W'(2);
    end else if (len < LEN_LIMIT_3B) begin
      h.bytes[0] = d | HDR_TAG_3B | 8'(len >> 16);
      h.bytes[1] = len[15:8];
      h.bytes[2] = len[7:0];
      h.count    = HDR_CNT_W'(3);
    end else if (len < LEN_LIMIT_4B) begin
      h.bytes[0] = d | HDR_TAG_4B | 8'(len >> 24);
      h.bytes[1] = len[23:16];
      h.bytes[2] = len[15:8];
      h.bytes[3] = len[7:0];
      h.count    = HDR_CNT_W'(4);
    end else begin
      h.bytes[0] = d | HDR_TAG_5B;
      h.bytes[1] = len[31:24];
      h.bytes[2] = len[23:16];
      h.bytes[3] = len[15:8];
      h.bytes[4] = len[7:0];
      h.count    = HDR_CNT_W'(5);
    end
    return h;
  endfunction

endpackage

[rtl/core/ftrb_ram.sv]
// ----------------------------------------------------------------------------
// ftrb_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ftrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/framed_trace_ring_buffer.sv]
// ----------------------------------------------------------------------------
// framed_trace_ring_buffer
// Trace capture buffer: records from one watched source are framed with a
// length-prefixed header and stored in a byte ring; read items drain it.
// ----------------------------------------------------------------------------
// channel  direction  handshake            contents
// s_*      in         s_tvalid / s_tready  action (tuser), record fields (tdata)
// m_*      out        m_tvalid / m_tready  read_valid (tuser), result (tdata)
// cfg_*    in         cfg_we               capture_enable, watched_index
//
// A matching header or payload item steps through ST_PUSH once per header byte
// or once for a payload byte; a byte dropped on a full ring still takes its
// ST_PUSH step. A read of a nonempty ring passes through ST_RDATA for the
// registered RAM read; other items go straight to ST_DONE. Reset clears state,
// pointers, fill count, configuration and output valid. A stalled result holds
// in the output register; the next item is worked on and waits in ST_DONE.
// ----------------------------------------------------------------------------
module framed_trace_ring_buffer
  import ftrb_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [15:0] source_index, [16] direction, [48:17] record_length,
  // [56:49] payload_byte, [63:57] zero
  input  logic [S_TDATA_W-1:0]  s_tdata,
  // [1:0] action
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [7:0] read_byte, [10:8] bytes_stored, [20:11] fill_level, [23:21] zero
  output logic [M_TDATA_W-1:0]  m_tdata,
  // [0] read_valid
  output logic                  m_tuser,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam logic [AW-1:0] LAST_PTR = AW'(RING_DEPTH - 1);

  state_t               state, state_next;
  logic [AW-1:0]        wr_ptr, wr_ptr_next;
  logic [AW-1:0]        rd_ptr, rd_ptr_next;
  logic [AW-1:0]        fill, fill_next;
  logic                 cap_en;
  logic signed [16:0]   watched;
  hdr_bytes_t           hdr_bytes, hdr_bytes_next;
  logic [HDR_CNT_W-1:0] hdr_left, hdr_left_next;
  logic [7:0]           res_byte, res_byte_next;
  logic                 res_valid, res_valid_next;
  logic [HDR_CNT_W-1:0] res_stored, res_stored_next;
  logic                 m_tvalid_next;
  logic [M_TDATA_W-1:0] m_tdata_next;
  logic                 m_tuser_next;

  logic                 ram_we, ram_re;
  logic [7:0]           ram_rdata;
  logic                 src_match;
  logic                 ring_full;
  hdr_t                 hdr;
  action_t              act;

  assign act       = action_t'(s_tuser);
  assign src_match = cap_en && !watched[16] && (watched[15:0] == s_tdata[15:0]);
  assign ring_full = (fill == LAST_PTR);
  assign hdr       = encode_header(s_tdata[16], s_tdata[48:17]);
  assign s_tready  = (state == ST_IDLE);

  ftrb_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata (hdr_bytes[0]),
    .re    (ram_re),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_en  <= 1'b0;
      watched <= -17'sd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CAPTURE_ENABLE: cap_en  <= cfg_data[0];
        CFG_WATCHED_INDEX:  watched <= cfg_data;
        default:            cap_en  <= cap_en;
      endcase
    end
  end

  always_comb begin
    state_next      = state;
    wr_ptr_next     = wr_ptr;
    rd_ptr_next     = rd_ptr;
    fill_next       = fill;
    hdr_bytes_next  = hdr_bytes;
    hdr_left_next   = hdr_left;
    res_byte_next   = res_byte;
    res_valid_next  = res_valid;
    res_stored_next = res_stored;
    m_tvalid_next   = m_tvalid && !m_tready;
    m_tdata_next    = m_tdata;
    m_tuser_next    = m_tuser;
    ram_we          = 1'b0;
    ram_re          = 1'b0;

    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          res_byte_next   = '0;
          res_valid_next  = 1'b0;
          res_stored_next = '0;
          state_next      = ST_DONE;
          case (act)
            ACT_HEADER: begin
              if (src_match) begin
                hdr_bytes_next = hdr.bytes;
                hdr_left_next  = hdr.count;
                state_next     = ST_PUSH;
              end
            end
            ACT_PAYLOAD: begin
              if (src_match) begin
                hdr_bytes_next = {32'h0, s_tdata[56:49]};
                hdr_left_next  = HDR_CNT_W'(1);
                state_next     = ST_PUSH;
              end
            end
            ACT_READ: begin
              if (fill != '0) begin
                ram_re     = 1'b1;
                state_next = ST_RDATA;
              end
            end
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_PUSH: begin
        if (!ring_full) begin
          ram_we          = 1'b1;
          wr_ptr_next     = (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
          fill_next       = fill + AW'(1);
          res_stored_next = res_stored + HDR_CNT_W'(1);
        end
        hdr_bytes_next = {8'h00, hdr_bytes[HDR_MAX_BYTES-1:1]};
        hdr_left_next  = hdr_left - HDR_CNT_W'(1);
        if (hdr_left == HDR_CNT_W'(1)) begin
          state_next = ST_DONE;
        end
      end
      ST_RDATA: begin
        res_byte_next  = ram_rdata;
        res_valid_next = 1'b1;
        rd_ptr_next    = (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
        fill_next      = fill - AW'(1);
        state_next     = ST_DONE;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = {3'b000, FILL_OUT_W'(fill), res_stored, res_byte};
          m_tuser_next  = res_valid;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fill     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      wr_ptr   <= wr_ptr_next;
      rd_ptr   <= rd_ptr_next;
      fill     <= fill_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    hdr_bytes  <= hdr_bytes_next;
    hdr_left   <= hdr_left_next;
    res_byte   <= res_byte_next;
    res_valid  <= res_valid_next;
    res_stored <= res_stored_next;
    m_tdata    <= m_tdata_next;
    m_tuser    <= m_tuser_next;
  end

`ifndef SYNTHESIS
  a_ptr_fill_consistent: assert property (@(posedge clk) disable iff (rst)
    ((({1'b0, rd_ptr} + {1'b0, fill}) >= (AW + 1)'(RING_DEPTH)) ?
      (wr_ptr == AW'(({1'b0, rd_ptr} + {1'b0, fill}) - (AW + 1)'(RING_DEPTH))) :
      (wr_ptr == (rd_ptr + fill))))
    else $error("write pointer does not match read pointer plus fill");

  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !ring_full)
    else $error("ring written while full");

  a_read_result_stores_nothing: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[10:8] == 3'd0)
    else $error("read result reports stored bytes");

  a_rdata_after_read: assert property (@(posedge clk) disable iff (rst)
    state == ST_RDATA |-> $past(s_tvalid && s_tready && s_tuser == ACT_READ))
    else $error("read data state without an accepted read transaction");
`endif

endmodule
